// ----- hw/rtl/fsgs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types and codes of the falling-sand grid block.
// ----------------------------------------------------------------------------
package fsgs_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_SAND  = 2'd1;
  localparam logic [1:0] CELL_WATER = 2'd2;
  localparam logic [1:0] CELL_SNOW  = 2'd3;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] LFSR_RESET = 16'h0001;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic [1:0] cell_kind;
  } req_t;

  typedef struct packed {
    logic [1:0] read_kind;
    logic       done_res;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD_WAIT,
    ST_CELL,
    ST_CELL_WAIT,
    ST_NB,
    ST_NB_WAIT,
    ST_DECIDE,
    ST_WR_SRC,
    ST_NEXT,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

// ----- hw/rtl/falling_sand_grid_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Falling-sand grid: cell write, cell read and one in-place simulation step.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (req_valid_i / req_stall_o): one request = write, read or step.
//   out channel (rsp_valid_o / rsp_stall_i): exactly one response per request.
//   cfg channel (cfg_valid_i / cfg_ready_o): index 0 columns, index 1 rows.
// A step visits every simulated cell above the bottom row with one shared
// single-port grid RAM: an empty cell is only read, a particle also reads
// its neighbors (at most 5; any past an edge is skipped) and, when it
// moves, writes its destination and its source, so a step's length
// depends on contents. Requests are handled one at a time.
// After reset the block sweeps the RAM to empty, one cell a cycle, and
// stalls requests meanwhile.
// The response is held in an output register while rsp_stall_i is high; a
// new request may be taken meanwhile, and its own response waits until the
// register is free.
// ----------------------------------------------------------------------------
module falling_sand_grid_step #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_stall_o,
  input  wire fsgs_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_stall_i,
  output fsgs_pkg::rsp_t       rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [6:0]      cfg_data_i
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CCW   = CW + 1;
  localparam int RCW   = RW + 1;
  localparam int SW    = (CCW > 7) ? CCW : 7;
  localparam int SRW   = (RCW > 7) ? RCW : 7;

  fsgs_pkg::state_e state_q, state_d;

  logic [6:0]     cols_cfg_q, rows_cfg_q;
  logic [CCW-1:0] cols_eff;
  logic [RCW-1:0] rows_eff;
  logic [15:0]    lfsr_q, lfsr_d;
  logic [CW-1:0]  c_q, c_d;
  logic [RW-1:0]  r_q, r_d;
  logic [1:0]     kind_q, kind_d;
  logic [1:0]     cur_q, cur_d;
  logic [2:0]     nb_q, nb_d;
  logic [4:0]     emp_q, emp_d;
  logic [1:0]     rd_q, rd_d;
  logic [1:0]     below_q, below_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           clr_done_q, clr_done_d;
  logic           is_read_q, is_read_d;
  logic [AW-1:0]  tgt_q, tgt_d;
  logic [1:0]     src_val_q, src_val_d;
  logic           rsp_valid_q, rsp_valid_d;
  logic [1:0]     rsp_kind_q, rsp_kind_d;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [1:0]     ram_wdata, ram_rdata;

  fsgs_ram #(.Width(2), .Depth(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign cols_eff = (SW'(cols_cfg_q) > SW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_cfg_q);
  assign rows_eff = (SRW'(rows_cfg_q) > SRW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_cfg_q);

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // base-4 digit sum keeps the value mod 3
  function automatic logic [1:0] mod3_16(input logic [15:0] x);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) s = s + 5'(x[2*i +: 2]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    case (u)
      3'd3: return 2'd0;
      3'd4: return 2'd1;
      default: return u[1:0];
    endcase
  endfunction

  // neighbor order: 0 below, 1 lower-left, 2 lower-right, 3 left, 4 right
  logic           nb_ok;
  logic [CW-1:0]  nb_c;
  logic [RW-1:0]  nb_r;
  logic           has_left, has_right;
  assign has_left  = (c_q != '0);
  assign has_right = (CCW'(c_q) + CCW'(1)) < cols_eff;

  always_comb begin
    nb_c  = c_q;
    nb_r  = r_q + RW'(1);
    nb_ok = 1'b1;
    case (nb_q)
      3'd0: nb_ok = 1'b1;
      3'd1: begin
        nb_c = c_q - CW'(1);
        nb_ok = has_left;
      end
      3'd2: begin
        nb_c = c_q + CW'(1);
        nb_ok = has_right;
      end
      3'd3: begin
        nb_c = c_q - CW'(1);
        nb_r = r_q;
        nb_ok = has_left && (cur_q == fsgs_pkg::CELL_WATER);
      end
      3'd4: begin
        nb_c = c_q + CW'(1);
        nb_r = r_q;
        nb_ok = has_right && (cur_q == fsgs_pkg::CELL_WATER);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  logic nb_last;
  assign nb_last = (cur_q == fsgs_pkg::CELL_WATER) ? (nb_q == 3'd4) : (nb_q == 3'd2);

  logic in_area;
  assign in_area = (CCW'(req_i.col) < cols_eff) && (CCW'(req_i.col) < CCW'(MAX_COLS))
                && (RCW'(req_i.row) < rows_eff) && (RCW'(req_i.row) < RCW'(MAX_ROWS));

  logic req_acc;
  assign req_acc     = (state_q == fsgs_pkg::ST_IDLE) && req_valid_i;
  assign req_stall_o = (state_q != fsgs_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // snow pick decode
  logic [15:0] lfsr_nx;
  logic [1:0]  n_cand;
  logic [1:0]  pick;
  logic [1:0]  m3;
  logic [2:0]  snow_cand;
  assign lfsr_nx   = lfsr_q[0] ? ((lfsr_q >> 1) ^ fsgs_pkg::LFSR_TAPS) : (lfsr_q >> 1);
  assign snow_cand = {emp_q[2], emp_q[0], emp_q[1]};
  assign n_cand    = 2'($countones(snow_cand));
  assign m3        = mod3_16(lfsr_nx);
  always_comb begin
    pick = 2'd0;
    if (n_cand == 2'd2) pick = {1'b0, lfsr_nx[0]};
    else if (n_cand == 2'd3) pick = m3;
  end

  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    r_d         = r_q;
    kind_d      = kind_q;
    cur_d       = cur_q;
    nb_d        = nb_q;
    emp_d       = emp_q;
    rd_d        = rd_q;
    clr_d       = clr_q;
    clr_done_d  = clr_done_q;
    is_read_d   = is_read_q;
    tgt_d       = tgt_q;
    src_val_d   = src_val_q;
    lfsr_d      = lfsr_q;
    rsp_valid_d = rsp_valid_q;
    rsp_kind_d  = rsp_kind_q;
    ram_we      = 1'b0;
    ram_addr    = addr_of(c_q, r_q);
    ram_wdata   = fsgs_pkg::CELL_EMPTY;
    case (state_q)
      fsgs_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_done_d = 1'b1;
          state_d    = fsgs_pkg::ST_IDLE;
        end
      end
      fsgs_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          kind_d    = req_i.kind;
          rd_d      = fsgs_pkg::CELL_EMPTY;
          c_d       = CW'(req_i.col);
          r_d       = RW'(req_i.row);
          is_read_d = 1'b0;
          state_d   = fsgs_pkg::ST_RESP;
          case (req_i.kind)
            fsgs_pkg::KIND_WRITE: begin
              ram_addr  = addr_of(CW'(req_i.col), RW'(req_i.row));
              ram_wdata = req_i.cell_kind;
              ram_we    = in_area;
            end
            fsgs_pkg::KIND_READ: begin
              ram_addr = addr_of(CW'(req_i.col), RW'(req_i.row));
              if (in_area) begin
                is_read_d = 1'b1;
                state_d   = fsgs_pkg::ST_RD_WAIT;
              end
            end
            fsgs_pkg::KIND_STEP: begin
              if (cols_eff != '0 && rows_eff >= RCW'(2)) begin
                c_d     = '0;
                r_d     = RW'(rows_eff - RCW'(2));
                state_d = fsgs_pkg::ST_CELL;
              end
            end
            default: state_d = fsgs_pkg::ST_RESP;
          endcase
        end
      end
      fsgs_pkg::ST_RD_WAIT: state_d = fsgs_pkg::ST_DECIDE;
      fsgs_pkg::ST_CELL: begin
        ram_addr = addr_of(c_q, r_q);
        state_d  = fsgs_pkg::ST_CELL_WAIT;
      end
      fsgs_pkg::ST_CELL_WAIT: begin
        state_d = fsgs_pkg::ST_NB;
        nb_d    = 3'd0;
        emp_d   = '0;
      end
      fsgs_pkg::ST_NB: begin
        if (nb_q == 3'd0) cur_d = ram_rdata;
        if (nb_q == 3'd0 && ram_rdata == fsgs_pkg::CELL_EMPTY) begin
          state_d = fsgs_pkg::ST_NEXT;
        end else if (nb_ok) begin
          ram_addr = addr_of(nb_c, nb_r);
          state_d  = fsgs_pkg::ST_NB_WAIT;
        end else if (nb_last) begin
          state_d = fsgs_pkg::ST_DECIDE;
        end else begin
          nb_d = nb_q + 3'd1;
        end
      end
      fsgs_pkg::ST_NB_WAIT: begin
        state_d = fsgs_pkg::ST_DECIDE;
        if (!nb_last) state_d = fsgs_pkg::ST_NB;
        emp_d[nb_q] = 1'b0;
        state_d = nb_last ? fsgs_pkg::ST_DECIDE : fsgs_pkg::ST_NB;
        nb_d = nb_q + 3'd1;
      end
      fsgs_pkg::ST_DECIDE: begin
        state_d = fsgs_pkg::ST_NEXT;
        if (is_read_q) begin
          rd_d    = ram_rdata;
          state_d = fsgs_pkg::ST_RESP;
        end else begin
          src_val_d = fsgs_pkg::CELL_EMPTY;
          case (cur_q)
            fsgs_pkg::CELL_SAND: begin
              if (emp_q[0]) begin
                tgt_d = addr_of(c_q, r_q + RW'(1)); state_d = fsgs_pkg::ST_WR_SRC;
              end else if (below_q == fsgs_pkg::CELL_WATER) begin
                tgt_d = addr_of(c_q, r_q + RW'(1)); src_val_d = fsgs_pkg::CELL_WATER;
                state_d = fsgs_pkg::ST_WR_SRC;
              end else if (emp_q[1]) begin
                tgt_d = addr_of(c_q - CW'(1), r_q + RW'(1)); state_d = fsgs_pkg::ST_WR_SRC;
              end else if (emp_q[2]) begin
                tgt_d = addr_of(c_q + CW'(1), r_q + RW'(1)); state_d = fsgs_pkg::ST_WR_SRC;
              end
            end
            fsgs_pkg::CELL_WATER: begin
              if (emp_q[0]) begin
                tgt_d = addr_of(c_q, r_q + RW'(1)); state_d = fsgs_pkg::ST_WR_SRC;
              end else if (emp_q[1]) begin
                tgt_d = addr_of(c_q - CW'(1), r_q + RW'(1)); state_d = fsgs_pkg::ST_WR_SRC;
              end else if (emp_q[2]) begin
                tgt_d = addr_of(c_q + CW'(1), r_q + RW'(1)); state_d = fsgs_pkg::ST_WR_SRC;
              end else if (emp_q[3]) begin
                tgt_d = addr_of(c_q - CW'(1), r_q); state_d = fsgs_pkg::ST_WR_SRC;
              end else if (emp_q[4]) begin
                tgt_d = addr_of(c_q + CW'(1), r_q); state_d = fsgs_pkg::ST_WR_SRC;
              end
            end
            fsgs_pkg::CELL_SNOW: begin
              if (n_cand != 2'd0) begin
                lfsr_d  = lfsr_nx;
                state_d = fsgs_pkg::ST_WR_SRC;
                if (pick == 2'd0 && snow_cand[0]) begin
                  tgt_d = addr_of(c_q - CW'(1), r_q + RW'(1));
                end else if ((pick == 2'd0 && !snow_cand[0] && snow_cand[1])
                          || (pick == 2'd1 && snow_cand[0] && snow_cand[1])) begin
                  tgt_d = addr_of(c_q, r_q + RW'(1));
                end else begin
                  tgt_d = addr_of(c_q + CW'(1), r_q + RW'(1));
                end
              end
            end
            default: state_d = fsgs_pkg::ST_NEXT;
          endcase
        end
        // destination write
        if (state_d == fsgs_pkg::ST_WR_SRC) begin
          ram_we    = 1'b1;
          ram_addr  = tgt_d;
          ram_wdata = cur_q;
        end
      end
      fsgs_pkg::ST_WR_SRC: begin
        ram_we    = 1'b1;
        ram_addr  = addr_of(c_q, r_q);
        ram_wdata = src_val_q;
        state_d   = fsgs_pkg::ST_NEXT;
      end
      fsgs_pkg::ST_NEXT: begin
        state_d = fsgs_pkg::ST_CELL;
        if ((CCW'(c_q) + CCW'(1)) < cols_eff) begin
          c_d = c_q + CW'(1);
        end else begin
          c_d = '0;
          if (r_q == '0) state_d = fsgs_pkg::ST_RESP;
          else r_d = r_q - RW'(1);
        end
      end
      fsgs_pkg::ST_RESP: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_valid_d = 1'b1;
          rsp_kind_d  = rd_q;
          state_d     = fsgs_pkg::ST_IDLE;
        end
      end
      default: state_d = fsgs_pkg::ST_IDLE;
    endcase
    if (rsp_valid_q && !rsp_stall_i && state_q != fsgs_pkg::ST_RESP) rsp_valid_d = 1'b0;
    if (state_q == fsgs_pkg::ST_RESP && rsp_valid_q && rsp_stall_i) rsp_valid_d = 1'b1;
  end

  // neighbor capture: empty flag and below value
  logic [4:0] emp_cap;
  always_comb begin
    emp_cap = emp_d;
    if (state_q == fsgs_pkg::ST_NB_WAIT) begin
      emp_cap[nb_q] = (ram_rdata == fsgs_pkg::CELL_EMPTY);
    end
  end
  always_comb begin
    below_d = below_q;
    if (state_q == fsgs_pkg::ST_NB_WAIT && nb_q == 3'd0) below_d = ram_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsgs_pkg::ST_CLEAR;
      cols_cfg_q  <= 7'd64;
      rows_cfg_q  <= 7'd64;
      lfsr_q      <= fsgs_pkg::LFSR_RESET;
      clr_q       <= '0;
      clr_done_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      clr_q       <= clr_d;
      clr_done_q  <= clr_done_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == fsgs_pkg::CFG_COLS) cols_cfg_q <= cfg_data_i;
        else rows_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    r_q       <= r_d;
    kind_q    <= kind_d;
    cur_q     <= cur_d;
    nb_q      <= nb_d;
    emp_q     <= emp_cap;
    rd_q      <= rd_d;
    below_q   <= below_d;
    is_read_q <= is_read_d;
    tgt_q     <= tgt_d;
    src_val_q <= src_val_d;
    rsp_kind_q <= rsp_kind_d;
  end

  assign rsp_valid_o      = rsp_valid_q;
  assign rsp_o.read_kind  = rsp_kind_q;
  assign rsp_o.done_res   = 1'b1;

  logic unused_ok;
  assign unused_ok = ^{kind_q, req_acc, clr_done_q};

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 16'd0) else $error("lfsr stuck at zero");
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fsgs_pkg::ST_CLEAR) |-> req_stall_o) else $error("request during clear");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=> (rsp_valid_o && $stable(rsp_o)))
    else $error("response dropped under stall");

endmodule
`default_nettype wire

// ----- hw/rtl/fsgs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsgs_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fsgs_ram #(
  parameter int Width = 2,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire
